[rtl/core/esc_pkg.sv]
// shared types and fixed field widths for the elevator scan controller
// no dependencies; compiled first
`default_nettype none

package esc_pkg;

    localparam int FLOOR_W = 4;
    localparam int PEND_W  = 5;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_CALL = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_MOVING = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        HEAD_NONE = 2'd0,
        HEAD_UP   = 2'd1,
        HEAD_DOWN = 2'd2
    } head_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        mode_t              car_mode;
        head_t              heading;
        logic               target_valid;
        logic [FLOOR_W-1:0] target_floor;
        logic [PEND_W-1:0]  pending;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/esc_in_if.sv]
// input channel of the elevator scan controller: tick or call items
// depends on esc_pkg
`default_nettype none

interface esc_in_if;
    import esc_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [FLOOR_W-1:0] floor;

    modport source (output valid, output cmd, output floor, input ready);
    modport sink   (input valid, input cmd, input floor, output ready);
endinterface

`default_nettype wire

[rtl/core/esc_out_if.sv]
// result channel of the elevator scan controller: car status items
// depends on esc_pkg
`default_nettype none

interface esc_out_if;
    import esc_pkg::*;

    logic               valid;
    logic               ready;
    logic [FLOOR_W-1:0] car_floor;
    logic [1:0]         car_mode;
    logic [1:0]         heading;
    logic               target_valid;
    logic [FLOOR_W-1:0] target_floor;
    logic [PEND_W-1:0]  pending;

    modport source (output valid, output car_floor, output car_mode, output heading,
                    output target_valid, output target_floor, output pending,
                    input ready);
    modport sink   (input valid, input car_floor, input car_mode, input heading,
                    input target_valid, input target_floor, input pending,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/esc_scan.sv]
// next-target search: farthest call ahead of the target, else farthest behind
// two priority encoders over the call bitmap; no package dependency
`default_nettype none

module esc_scan #(
    parameter int FLOORS = 16,
    parameter int FW     = 4
) (
    input  wire logic [FLOORS-1:0] calls,
    input  wire logic [FW-1:0]     target,
    input  wire logic              going_up,
    output logic                   found,
    output logic [FW-1:0]          next_target
);

    logic          hi_found;
    logic [FW-1:0] hi_floor;
    logic          lo_found;
    logic [FW-1:0] lo_floor;

    // highest marked floor above target: ascending, last hit wins
    always_comb
    begin
        hi_found = 1'b0;
        hi_floor = '0;
        for (int i = 0; i < FLOORS; i++)
        begin
            if (calls[i] && (FW'(i) > target))
            begin
                hi_found = 1'b1;
                hi_floor = FW'(i);
            end
        end
    end

    // lowest marked floor below target: descending, last hit wins
    always_comb
    begin
        lo_found = 1'b0;
        lo_floor = '0;
        for (int i = FLOORS - 1; i >= 0; i--)
        begin
            if (calls[i] && (FW'(i) < target))
            begin
                lo_found = 1'b1;
                lo_floor = FW'(i);
            end
        end
    end

    always_comb
    begin
        found       = hi_found || lo_found;
        next_target = target;
        if (going_up)
        begin
            if (hi_found)
                next_target = hi_floor;
            else if (lo_found)
                next_target = lo_floor;
        end
        else
        begin
            if (lo_found)
                next_target = lo_floor;
            else if (hi_found)
                next_target = hi_floor;
        end
    end

endmodule

`default_nettype wire

[rtl/core/esc_step.sv]
// next-state logic for one item (tick or call) and the result it produces
// depends on esc_pkg and esc_scan
`default_nettype none

module esc_step #(
    parameter int FLOORS = 16,
    parameter int FW     = 4,
    parameter int CW     = 5
) (
    input  wire logic                    cmd,
    input  wire logic [esc_pkg::FLOOR_W-1:0] floor,
    input  wire logic [FLOORS-1:0]       calls,
    input  wire logic [CW-1:0]           count,
    input  wire logic [FW-1:0]           car,
    input  wire esc_pkg::mode_t          mode,
    input  wire esc_pkg::head_t          head,
    input  wire logic [FW-1:0]           target,
    input  wire logic                    target_set,
    output logic [FLOORS-1:0]            calls_next,
    output logic [CW-1:0]                count_next,
    output logic [FW-1:0]                car_next,
    output esc_pkg::mode_t               mode_next,
    output esc_pkg::head_t               head_next,
    output logic [FW-1:0]                target_next,
    output logic                         target_set_next,
    output esc_pkg::result_t             result
);
    import esc_pkg::*;

    localparam logic [FW:0]   FLOORS_V = (FW + 1)'(FLOORS);
    localparam logic [FW-1:0] TOP      = FW'(FLOORS - 1);

    logic [FW-1:0]     req_floor;
    logic              req_in_range;
    logic [FLOORS-1:0] req_mask;
    logic              req_marked;
    logic [FW-1:0]     stepped;
    logic [FLOORS-1:0] step_mask;
    logic              step_marked;
    logic [FLOORS-1:0] calls_cleared;
    logic [CW-1:0]     count_dec;
    logic              scan_found;
    logic [FW-1:0]     scan_target;
    logic [FW-1:0]     chosen;

    assign req_floor    = FW'(floor);
    assign req_in_range = {1'b0, req_floor} < FLOORS_V;
    assign req_mask     = FLOORS'(1) << req_floor;
    assign req_marked   = |(calls & req_mask);

    always_comb
    begin
        stepped = car;
        if (head == HEAD_UP)
        begin
            if (car != TOP)
                stepped = car + FW'(1);
        end
        else if (car != '0)
        begin
            stepped = car - FW'(1);
        end
    end

    assign step_mask     = FLOORS'(1) << stepped;
    assign step_marked   = |(calls & step_mask);
    assign calls_cleared = calls & ~step_mask;
    assign count_dec     = (count != '0) ? count - CW'(1) : count;

    esc_scan #(
        .FLOORS (FLOORS),
        .FW     (FW)
    ) u_scan (
        .calls       (calls_cleared),
        .target      (target),
        .going_up    (head == HEAD_UP),
        .found       (scan_found),
        .next_target (scan_target)
    );

    assign chosen = scan_found ? scan_target : target;

    always_comb
    begin
        calls_next      = calls;
        count_next      = count;
        car_next        = car;
        mode_next       = mode;
        head_next       = head;
        target_next     = target;
        target_set_next = target_set;

        if (cmd == CMD_CALL)
        begin
            // call for the car's own floor while parked with no target is dropped
            if (req_in_range && !(mode == MODE_IDLE && !target_set && req_floor == car))
            begin
                if (!req_marked)
                begin
                    calls_next = calls | req_mask;
                    count_next = count + CW'(1);
                end
                if (!target_set)
                begin
                    target_next     = req_floor;
                    target_set_next = 1'b1;
                end
            end
        end
        else if (mode == MODE_IDLE)
        begin
            if (count != '0)
            begin
                head_next = (car > target) ? HEAD_DOWN : HEAD_UP;
                mode_next = MODE_MOVING;
            end
        end
        else
        begin
            car_next = stepped;
            if (step_marked)
            begin
                mode_next  = MODE_OPEN;
                calls_next = calls_cleared;
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    mode_next       = MODE_IDLE;
                    head_next       = HEAD_NONE;
                    target_next     = '0;
                    target_set_next = 1'b0;
                end
                else if (target_set && stepped == target)
                begin
                    target_next = chosen;
                    head_next   = (stepped > chosen) ? HEAD_DOWN : HEAD_UP;
                end
            end
            else
            begin
                mode_next = MODE_MOVING;
            end
        end
    end

    always_comb
    begin
        result.car_floor    = car_next[FLOOR_W-1:0];
        result.car_mode     = mode_next;
        result.heading      = head_next;
        result.target_valid = target_set_next;
        result.target_floor = target_set_next ? target_next[FLOOR_W-1:0] : '0;
        result.pending      = count_next[PEND_W-1:0];
    end

endmodule

`default_nettype wire

[rtl/core/elevator_scan_controller_unit.sv]
// top level of the single-car scan elevator controller
// depends on esc_pkg, esc_in_if, esc_out_if, esc_step (and esc_scan below it)
`default_nettype none

// Single-car elevator controller using the scan scheme. Each input item is
// either a tick (cmd 0) or a floor call (cmd 1, floor field). Every item
// yields exactly one result item with the car floor, mode, heading, target and
// number of pending calls after that item. One item is accepted per clock
// cycle while the result channel is not stalled; each item passes through the
// input register, then the result register, and leaves as a result. The rate
// is set by the single-pass next-state logic, whose longest path is the pair
// of priority encoders over the call bitmap that pick the next target. When
// the result register is full and not taken, the input register still takes
// one more item before ready drops. Calls for floors at or above FLOORS are
// ignored; the car saturates at the bottom and top floors.

module elevator_scan_controller_unit #(
    parameter int FLOORS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    esc_in_if.sink      req,
    esc_out_if.source   res
);
    import esc_pkg::*;

    // floor index and count widths never drop below the result field widths
    localparam int FW = ($clog2(FLOORS) > FLOOR_W) ? $clog2(FLOORS) : FLOOR_W;
    localparam int CW = ($clog2(FLOORS + 1) > PEND_W) ? $clog2(FLOORS + 1) : PEND_W;

    // input register
    logic               in_valid_reg;
    logic               in_cmd_reg;
    logic [FLOOR_W-1:0] in_floor_reg;

    // controller state
    logic [FLOORS-1:0]  calls_reg;
    logic [CW-1:0]      count_reg;
    logic [FW-1:0]      car_reg;
    mode_t              mode_reg;
    head_t              head_reg;
    logic [FW-1:0]      target_reg;
    logic               target_set_reg;

    logic [FLOORS-1:0]  calls_next;
    logic [CW-1:0]      count_next;
    logic [FW-1:0]      car_next;
    mode_t              mode_next;
    head_t              head_next;
    logic [FW-1:0]      target_next;
    logic               target_set_next;
    result_t            result_next;

    // result register
    logic               out_valid_reg;
    result_t            out_reg;

    logic               advance;

    // the pipe moves when the result register is empty or being drained
    assign advance   = !out_valid_reg || res.ready;
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_cmd_reg   <= req.cmd;
            in_floor_reg <= req.floor;
        end
    end

    esc_step #(
        .FLOORS (FLOORS),
        .FW     (FW),
        .CW     (CW)
    ) u_step (
        .cmd             (in_cmd_reg),
        .floor           (in_floor_reg),
        .calls           (calls_reg),
        .count           (count_reg),
        .car             (car_reg),
        .mode            (mode_reg),
        .head            (head_reg),
        .target          (target_reg),
        .target_set      (target_set_reg),
        .calls_next      (calls_next),
        .count_next      (count_next),
        .car_next        (car_next),
        .mode_next       (mode_next),
        .head_next       (head_next),
        .target_next     (target_next),
        .target_set_next (target_set_next),
        .result          (result_next)
    );

    // state commits once per item, as it moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calls_reg      <= '0;
            count_reg      <= '0;
            car_reg        <= '0;
            mode_reg       <= MODE_IDLE;
            head_reg       <= HEAD_NONE;
            target_reg     <= '0;
            target_set_reg <= 1'b0;
        end
        else if (in_valid_reg && advance)
        begin
            calls_reg      <= calls_next;
            count_reg      <= count_next;
            car_reg        <= car_next;
            mode_reg       <= mode_next;
            head_reg       <= head_next;
            target_reg     <= target_next;
            target_set_reg <= target_set_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_reg <= result_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.car_floor    = out_reg.car_floor;
    assign res.car_mode     = out_reg.car_mode;
    assign res.heading      = out_reg.heading;
    assign res.target_valid = out_reg.target_valid;
    assign res.target_floor = out_reg.target_floor;
    assign res.pending      = out_reg.pending;

    // pending count always matches the number of marked floors
    a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(calls_reg) == 32'(count_reg))
        else $error("pending count disagrees with call bitmap");

    // a parked car has no heading
    a_idle_no_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (head_reg == HEAD_NONE))
        else $error("idle car has a heading");

    // no target means the target register is cleared
    a_target_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !target_set_reg |-> (target_reg == '0))
        else $error("target register not cleared without a target");

    // a held result freezes the controller state
    a_stall_freezes_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=>
            ($stable(car_reg) && $stable(calls_reg) && $stable(mode_reg)))
        else $error("state advanced while result was stalled");

    // the car never leaves the shaft
    a_car_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(car_reg) < FLOORS)
        else $error("car floor out of range");

endmodule

`default_nettype wire
